@@ rtl/tcsw_pkg.sv @@
// ----------------------------------------------------------------------------
// tcsw_pkg
// Shared types and constants of the text console scroll writer: request
// codes, register indexes, field widths and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package tcsw_pkg;

   // request kinds
   localparam logic [1:0] REQ_PUT   = 2'd0;
   localparam logic [1:0] REQ_WRITE = 2'd1;
   localparam logic [1:0] REQ_CLEAR = 2'd2;
   localparam logic [1:0] REQ_READ  = 2'd3;

   // register indexes
   localparam int         CSR_IDX_W = 1;
   localparam logic [0:0] CSR_FG    = 1'b0;
   localparam logic [0:0] CSR_BG    = 1'b1;

   // field widths
   localparam int TYPE_W   = 2;
   localparam int CHAR_W   = 8;
   localparam int ROW_W    = 5;
   localparam int COL_W    = 7;
   localparam int COLOR_W  = 4;
   localparam int CELL_W   = 16;
   localparam int CURSOR_W = 7;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 24;

   localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
   localparam logic [CHAR_W-1:0]  SPACE_CHAR   = 8'h20;
   localparam logic [CELL_W-1:0]  CLEAR_CELL   = 16'h0F20;
   localparam logic [COLOR_W-1:0] FG_RESET     = 4'd15;
   localparam logic [COLOR_W-1:0] BG_RESET     = 4'd0;

   // write source select
   localparam logic [2:0] WSRC_CURSOR = 3'd0;
   localparam logic [2:0] WSRC_POS    = 3'd1;
   localparam logic [2:0] WSRC_MOVE   = 3'd2;
   localparam logic [2:0] WSRC_FILL   = 3'd3;
   localparam logic [2:0] WSRC_CLEAR  = 3'd4;
   localparam logic [2:0] WSRC_ZERO   = 3'd5;

   // read address select
   localparam logic RSRC_POS  = 1'b0;
   localparam logic RSRC_MOVE = 1'b1;

   typedef struct packed {
      logic       latch;
      logic       cnt_clr;
      logic       cnt_inc;
      logic       we;
      logic [2:0] wsrc;
      logic       re;
      logic       rsrc;
      logic       cur_inc;
      logic       cur_clr;
      logic       rsp_load;
      logic       rsp_read;
   } cmd_type;

   typedef struct packed {
      logic [TYPE_W-1:0] req_type;
      logic              newline;
      logic              line_full;
      logic              in_range;
      logic              cnt_zero;
      logic              move_end;
      logic              fill_end;
      logic              sweep_end;
      logic              out_free;
   } stat_type;

endpackage

@@ rtl/tcsw_ram.sv @@
// ----------------------------------------------------------------------------
// tcsw_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module tcsw_ram #(
   parameter  int WIDTH = 16,
   parameter  int DEPTH = 2000,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/tcsw_ctrl.sv @@
// ----------------------------------------------------------------------------
// tcsw_ctrl
// Sequencer of the console: request decode, scroll walk, screen sweeps and
// result hand-off.
// ----------------------------------------------------------------------------
module tcsw_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  tcsw_pkg::stat_type stat,
   output tcsw_pkg::cmd_type  cmd
);

   localparam logic [2:0] S_INIT   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_EXEC   = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_MOVE   = 3'd4;
   localparam logic [2:0] S_FILL   = 3'd5;
   localparam logic [2:0] S_CLEAR  = 3'd6;
   localparam logic [2:0] S_FINISH = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_INIT: begin
            // wipe the screen to zero after reset
            cmd.we      = 1'b1;
            cmd.wsrc    = tcsw_pkg::WSRC_ZERO;
            cmd.cnt_inc = 1'b1;
            if (stat.sweep_end) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            cmd.latch = accept;
            if (accept) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (stat.req_type)
               tcsw_pkg::REQ_PUT: begin
                  if (stat.newline || stat.line_full) begin
                     cmd.cnt_clr = 1'b1;
                     state_in    = S_MOVE;
                  end else if (stat.out_free) begin
                     cmd.we       = 1'b1;
                     cmd.wsrc     = tcsw_pkg::WSRC_CURSOR;
                     cmd.cur_inc  = 1'b1;
                     cmd.rsp_load = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               tcsw_pkg::REQ_WRITE: begin
                  if (stat.out_free) begin
                     cmd.we       = stat.in_range;
                     cmd.wsrc     = tcsw_pkg::WSRC_POS;
                     cmd.rsp_load = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
               tcsw_pkg::REQ_CLEAR: begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = S_CLEAR;
               end
               tcsw_pkg::REQ_READ: begin
                  cmd.re   = stat.in_range;
                  cmd.rsrc = tcsw_pkg::RSRC_POS;
                  state_in = S_READ;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_READ: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_read = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_MOVE: begin
            // read one row ahead, write the word read last cycle
            cmd.re      = !stat.move_end;
            cmd.rsrc    = tcsw_pkg::RSRC_MOVE;
            cmd.we      = !stat.cnt_zero;
            cmd.wsrc    = tcsw_pkg::WSRC_MOVE;
            cmd.cnt_inc = 1'b1;
            if (stat.move_end) begin
               cmd.cnt_clr = 1'b1;
               state_in    = S_FILL;
            end
         end
         S_FILL: begin
            cmd.we      = 1'b1;
            cmd.wsrc    = tcsw_pkg::WSRC_FILL;
            cmd.cnt_inc = 1'b1;
            if (stat.fill_end) begin
               cmd.cur_clr = 1'b1;
               // a character still has to land at column 0
               state_in    = stat.newline ? S_FINISH : S_EXEC;
            end
         end
         S_CLEAR: begin
            cmd.we      = 1'b1;
            cmd.wsrc    = tcsw_pkg::WSRC_CLEAR;
            cmd.cnt_inc = 1'b1;
            if (stat.sweep_end) begin
               cmd.cur_clr = 1'b1;
               state_in    = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_EXEC))
      else $error("accepted beat not followed by execute");

   a_move_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MOVE) && stat.move_end |=> (state_ff == S_FILL))
      else $error("scroll move did not hand over to row fill");

   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !cmd.we && !cmd.re && !cmd.rsp_load)
      else $error("memory or result touched while idle");

endmodule

@@ rtl/tcsw_datapath.sv @@
// ----------------------------------------------------------------------------
// tcsw_datapath
// Request holding registers, color registers, cursor, sweep counter, screen
// address/data selection and the result register.
// ----------------------------------------------------------------------------
module tcsw_datapath #(
   parameter  int COLUMNS = 80,
   parameter  int ROWS    = 25,
   localparam int TOTAL   = ROWS * COLUMNS,
   localparam int ADDR_W  = $clog2(TOTAL)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tcsw_pkg::cmd_type                       cmd,
   output tcsw_pkg::stat_type                      stat,
   input  logic [tcsw_pkg::TYPE_W-1:0]             req_type,
   input  logic [tcsw_pkg::CHAR_W-1:0]             char_code,
   input  logic [tcsw_pkg::ROW_W-1:0]              cell_row,
   input  logic [tcsw_pkg::COL_W-1:0]              cell_column,
   input  logic [tcsw_pkg::COLOR_W-1:0]            cell_foreground,
   input  logic [tcsw_pkg::COLOR_W-1:0]            cell_background,
   input  logic                                   csr_we,
   input  logic [tcsw_pkg::CSR_IDX_W-1:0]          csr_addr,
   input  logic [tcsw_pkg::COLOR_W-1:0]            csr_wdata,
   output logic                                   mem_we,
   output logic [ADDR_W-1:0]                      mem_waddr,
   output logic [tcsw_pkg::CELL_W-1:0]             mem_wdata,
   output logic                                   mem_re,
   output logic [ADDR_W-1:0]                      mem_raddr,
   input  logic [tcsw_pkg::CELL_W-1:0]             mem_rdata,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [tcsw_pkg::CELL_W-1:0]             rsp_read_value,
   output logic [tcsw_pkg::CURSOR_W-1:0]           rsp_cursor_column
);

   localparam int MOVE  = (ROWS - 1) * COLUMNS;
   localparam int CNT_W = $clog2(TOTAL + 1);
   localparam int CUR_W = $clog2(COLUMNS + 1);
   localparam int POS_W = ADDR_W + tcsw_pkg::COL_W + 1;

   logic [tcsw_pkg::TYPE_W-1:0]   type_ff;
   logic [tcsw_pkg::CHAR_W-1:0]   char_ff;
   logic [tcsw_pkg::ROW_W-1:0]    row_ff;
   logic [tcsw_pkg::COL_W-1:0]    col_ff;
   logic [tcsw_pkg::COLOR_W-1:0]  cfg_ff;
   logic [tcsw_pkg::COLOR_W-1:0]  cbg_ff;
   logic [tcsw_pkg::COLOR_W-1:0]  fg_ff;
   logic [tcsw_pkg::COLOR_W-1:0]  bg_ff;
   logic [CNT_W-1:0]             cnt_ff;
   logic [CNT_W-1:0]             cnt_in;
   logic [CUR_W-1:0]             cursor_ff;
   logic [CUR_W-1:0]             cursor_in;
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   logic [tcsw_pkg::CELL_W-1:0]   rsp_read_ff;
   logic [tcsw_pkg::CURSOR_W-1:0] rsp_cursor_ff;
   logic [POS_W-1:0]             pos_wide;
   logic [ADDR_W-1:0]            pos_addr;
   logic                         in_range;
   logic                         line_full;
   logic                         out_free;
   logic [CUR_W+tcsw_pkg::CURSOR_W-1:0] cursor_ext;

   assign pos_wide  = (POS_W'(row_ff) * POS_W'(COLUMNS)) + POS_W'(col_ff);
   assign pos_addr  = pos_wide[ADDR_W-1:0];
   assign in_range  = (32'(row_ff) < ROWS) && (32'(col_ff) < COLUMNS);
   assign line_full = (cursor_ff == CUR_W'(COLUMNS));
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      stat           = '0;
      stat.req_type  = type_ff;
      stat.newline   = (char_ff == tcsw_pkg::NEWLINE_CHAR);
      stat.line_full = line_full;
      stat.in_range  = in_range;
      stat.cnt_zero  = (cnt_ff == '0);
      stat.move_end  = (cnt_ff == CNT_W'(MOVE));
      stat.fill_end  = (cnt_ff == CNT_W'(COLUMNS - 1));
      stat.sweep_end = (cnt_ff == CNT_W'(TOTAL - 1));
      stat.out_free  = out_free;
   end

   // screen port selection
   always_comb begin
      mem_we    = cmd.we;
      mem_waddr = ADDR_W'(cnt_ff);
      mem_wdata = '0;
      case (cmd.wsrc)
         tcsw_pkg::WSRC_CURSOR: begin
            mem_waddr = ADDR_W'(MOVE) + ADDR_W'(cursor_ff);
            mem_wdata = {bg_ff, fg_ff, char_ff};
         end
         tcsw_pkg::WSRC_POS: begin
            mem_waddr = pos_addr;
            mem_wdata = {cbg_ff, cfg_ff, char_ff};
         end
         tcsw_pkg::WSRC_MOVE: begin
            mem_waddr = ADDR_W'(cnt_ff - 1'b1);
            mem_wdata = mem_rdata;
         end
         tcsw_pkg::WSRC_FILL: begin
            mem_waddr = ADDR_W'(CNT_W'(MOVE) + cnt_ff);
            mem_wdata = {bg_ff, bg_ff, tcsw_pkg::SPACE_CHAR};
         end
         tcsw_pkg::WSRC_CLEAR: begin
            mem_wdata = tcsw_pkg::CLEAR_CELL;
         end
         tcsw_pkg::WSRC_ZERO: begin
            mem_wdata = '0;
         end
         default: begin
            mem_wdata = '0;
         end
      endcase
   end

   assign mem_re    = cmd.re;
   assign mem_raddr = (cmd.rsrc == tcsw_pkg::RSRC_MOVE) ?
                      ADDR_W'(cnt_ff + CNT_W'(COLUMNS)) : pos_addr;

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.cnt_clr) begin
         cnt_in = '0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_comb begin
      cursor_in = cursor_ff;
      if (cmd.cur_clr) begin
         cursor_in = '0;
      end else if (cmd.cur_inc) begin
         cursor_in = cursor_ff + 1'b1;
      end
   end

   assign cursor_ext   = {{tcsw_pkg::CURSOR_W{1'b0}}, cursor_in};
   assign rsp_valid_in = cmd.rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         fg_ff        <= tcsw_pkg::FG_RESET;
         bg_ff        <= tcsw_pkg::BG_RESET;
      end else begin
         cnt_ff       <= cnt_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && (csr_addr == tcsw_pkg::CSR_FG)) begin
            fg_ff <= csr_wdata;
         end
         if (csr_we && (csr_addr == tcsw_pkg::CSR_BG)) begin
            bg_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         type_ff <= req_type;
         char_ff <= char_code;
         row_ff  <= cell_row;
         col_ff  <= cell_column;
         cfg_ff  <= cell_foreground;
         cbg_ff  <= cell_background;
      end
      if (cmd.rsp_load) begin
         rsp_read_ff   <= (cmd.rsp_read && in_range) ? mem_rdata : '0;
         rsp_cursor_ff <= cursor_ext[tcsw_pkg::CURSOR_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_value    = rsp_read_ff;
   assign rsp_cursor_column = rsp_cursor_ff;

   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      32'(cursor_ff) <= COLUMNS)
      else $error("cursor ran past the end of the line");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> out_free)
      else $error("result register overwritten while still held");

   a_cursor_write: assert property (@(posedge clock) disable iff (reset)
      cmd.we && (cmd.wsrc == tcsw_pkg::WSRC_CURSOR) |-> !line_full)
      else $error("cursor write on a full line");

endmodule

@@ rtl/text_console_scroll_writer.sv @@
// ----------------------------------------------------------------------------
// text_console_scroll_writer
// Text-mode console: a ROWS x COLUMNS screen of 16-bit cells with a cursor
// on the bottom row, scrolling, positioned writes, reads and clear.
// ----------------------------------------------------------------------------
// One request is handled at a time and each gives one result beat. A read
// result waits for the registered screen RAM read. A newline, or a
// character on a full line, scrolls first: the move walks (ROWS-1)*COLUMNS
// cells at one cell a cycle through the single-write RAM, its first step only
// priming the read, then the bottom row is filled. A clear writes every
// cell. After reset the screen is wiped to zero, during which no request is
// accepted; color registers can be written at any time the block is idle.
// The next request is accepted while a result beat is still waiting.
module text_console_scroll_writer #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // char_code[7:0], cell_row[12:8], cell_column[19:13],
   // cell_foreground[23:20], cell_background[27:24], zero pad
   input  logic [tcsw_pkg::REQ_DATA_W-1:0]        req_tdata,
   // req_type[1:0]
   input  logic [tcsw_pkg::TYPE_W-1:0]            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // read_value[15:0], cursor_column[22:16], zero pad
   output logic [tcsw_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   input  logic                                  csr_we,
   input  logic [tcsw_pkg::CSR_IDX_W-1:0]         csr_addr,
   input  logic [tcsw_pkg::COLOR_W-1:0]           csr_wdata
);

   localparam int TOTAL  = ROWS * COLUMNS;
   localparam int ADDR_W = $clog2(TOTAL);

   tcsw_pkg::cmd_type  cmd;
   tcsw_pkg::stat_type stat;

   logic                           mem_we;
   logic [ADDR_W-1:0]              mem_waddr;
   logic [tcsw_pkg::CELL_W-1:0]     mem_wdata;
   logic                           mem_re;
   logic [ADDR_W-1:0]              mem_raddr;
   logic [tcsw_pkg::CELL_W-1:0]     mem_rdata;
   logic [tcsw_pkg::CELL_W-1:0]     read_value;
   logic [tcsw_pkg::CURSOR_W-1:0]   cursor_column;

   tcsw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   tcsw_datapath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_type          (req_tuser),
      .char_code         (req_tdata[7:0]),
      .cell_row          (req_tdata[12:8]),
      .cell_column       (req_tdata[19:13]),
      .cell_foreground   (req_tdata[23:20]),
      .cell_background   (req_tdata[27:24]),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .mem_we            (mem_we),
      .mem_waddr         (mem_waddr),
      .mem_wdata         (mem_wdata),
      .mem_re            (mem_re),
      .mem_raddr         (mem_raddr),
      .mem_rdata         (mem_rdata),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_read_value    (read_value),
      .rsp_cursor_column (cursor_column)
   );

   tcsw_ram #(
      .WIDTH (tcsw_pkg::CELL_W),
      .DEPTH (TOTAL)
   ) u_screen (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   assign rsp_tdata = {1'b0, cursor_column, read_value};

endmodule
